[rtl/core/sorb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorb_pkg
// Shared widths, result kinds and register indexes of the reorder buffer.
// ----------------------------------------------------------------------------
package sorb_pkg;

   localparam int DEPTH_DEF    = 32;
   localparam int TAG_BITS_DEF = 10;

   localparam int SEQ_W     = 32;
   localparam int TIME_W    = 32;
   localparam int LEN_W     = 16;
   localparam int FLAGS_W   = 16;
   localparam int TIMEOUT_W = 31;
   localparam int KIND_W    = 3;
   localparam int START_W   = 4;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_FORWARD = 3'd0,
      KIND_RELEASE = 3'd1,
      KIND_LATE    = 3'd2,
      KIND_BAD     = 3'd3,
      KIND_FULL    = 3'd4
   } kind_type;

   localparam logic [1:0] REG_TIMEOUT     = 2'd0;
   localparam logic [1:0] REG_FLAGS_SEQ   = 2'd1;
   localparam logic [1:0] REG_FLAGS_PLAIN = 2'd2;

   localparam logic [FLAGS_W-1:0] FLAGS_SEQ_RESET   = 16'h3000;
   localparam logic [FLAGS_W-1:0] FLAGS_PLAIN_RESET = 16'h2000;

   localparam logic [START_W-1:0] START_SEQ   = 4'd12;
   localparam logic [START_W-1:0] START_PLAIN = 4'd8;

   // a serially after b, modulo 2^32
   function automatic logic seq_after(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return (d != '0) && !d[SEQ_W-1];
   endfunction

endpackage

[rtl/core/sorb_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorb_cell
// One slot of the rotating slot ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module sorb_cell #(
   parameter int TAG_BITS = sorb_pkg::TAG_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic                        in_valid,
   input  logic [sorb_pkg::SEQ_W-1:0]  in_seq,
   input  logic [sorb_pkg::TIME_W-1:0] in_time,
   input  logic [TAG_BITS-1:0]         in_tag,
   input  logic [sorb_pkg::LEN_W-1:0]  in_len,
   output logic                        out_valid,
   output logic [sorb_pkg::SEQ_W-1:0]  out_seq,
   output logic [sorb_pkg::TIME_W-1:0] out_time,
   output logic [TAG_BITS-1:0]         out_tag,
   output logic [sorb_pkg::LEN_W-1:0]  out_len
);
   import sorb_pkg::*;

   logic              valid_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic [TIME_W-1:0] time_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [LEN_W-1:0]  len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         seq_ff  <= in_seq;
         time_ff <= in_time;
         tag_ff  <= in_tag;
         len_ff  <= in_len;
      end
   end

   assign out_valid = valid_ff;
   assign out_seq   = seq_ff;
   assign out_time  = time_ff;
   assign out_tag   = tag_ff;
   assign out_len   = len_ff;

endmodule

[rtl/core/sequence_reorder_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Holds sequenced tunnel frame descriptors and releases them in order.
// ----------------------------------------------------------------------------
// Usage: a request (req_*) is a time update or a frame arrival. Each request
// yields zero or more results on rsp_*, the final one with rsp_last set.
// Held frames sit in a ring of DEPTH cells that rotates one cell per cycle
// during a sweep unless a result is held up; the controller works on the
// entry at the head of the ring.
// Sequence of a request: accept, classify, then for a held arrival a
// duplicate/free-slot sweep and a decide step, then one sweep per run of
// in-order releases or gap skip plus one more, then a stale-drop sweep and
// finish. req_stall is high until the request's last result sits in the
// output register. Requests are taken one at a time.
// Receiver stall: results wait in a pending stage and an output register;
// while both are full and rsp_stall is high a sweep with a result to emit freezes.
// Reset (synchronous): all slots empty, last released number all ones,
// registers at their reset values. Registers are at 0x0, 0x4, 0x8.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer #(
   parameter int DEPTH    = sorb_pkg::DEPTH_DEF,
   parameter int TAG_BITS = sorb_pkg::TAG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [sorb_pkg::TIME_W-1:0]    req_now_time,
   input  logic                           req_source_ok,
   input  logic [sorb_pkg::FLAGS_W-1:0]   req_flags_word,
   input  logic [sorb_pkg::SEQ_W-1:0]     req_seq_number,
   input  logic [TAG_BITS-1:0]            req_frame_tag,
   input  logic [sorb_pkg::LEN_W-1:0]     req_frame_size,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sorb_pkg::KIND_W-1:0]    rsp_kind,
   output logic [sorb_pkg::SEQ_W-1:0]     rsp_out_seq,
   output logic [TAG_BITS-1:0]            rsp_out_tag,
   output logic [sorb_pkg::START_W-1:0]   rsp_payload_start,
   output logic [sorb_pkg::LEN_W-1:0]     rsp_payload_len,
   output logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sorb_pkg::ADDR_W-1:0]    paddr,
   input  logic [sorb_pkg::DATA_W-1:0]    pwdata,
   output logic [sorb_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);
   import sorb_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ARRIVE, ST_SCAN, ST_DECIDE, ST_PASS, ST_DROP, ST_FINISH
   } state_type;

   // configuration
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [FLAGS_W-1:0]   flags_seq_ff, flags_plain_ff;
   logic                 csr_write;

   // request latch
   logic                action_ff, src_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [FLAGS_W-1:0]  flags_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [LEN_W-1:0]    size_ff;

   // sequencer
   state_type state_ff, state_in;
   logic [SEQ_W-1:0] lr_ff, lr_in;
   logic [IDX_W-1:0] pos_ff, pos_in, free_ff, free_in;
   logic dup_ff, dup_in, free_found_ff, free_found_in, insert_ff, insert_in;
   logic rel_ff, rel_in, exp_ff, exp_in, found_ff, found_in;
   logic [SEQ_W-1:0] best_ff, best_in;

   // pending result and output register
   logic pend_v_ff, pend_v_in;
   logic [KIND_W-1:0] pend_kind_ff, pend_kind_in;
   logic [SEQ_W-1:0] pend_seq_ff, pend_seq_in;
   logic [TAG_BITS-1:0] pend_tag_ff, pend_tag_in;
   logic [START_W-1:0] pend_start_ff, pend_start_in;
   logic [LEN_W-1:0] pend_len_ff, pend_len_in;
   logic out_v_ff, out_v_in, out_last_ff, out_last_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [SEQ_W-1:0] out_seq_ff, out_seq_in;
   logic [TAG_BITS-1:0] out_tag_ff, out_tag_in;
   logic [START_W-1:0] out_start_ff, out_start_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;

   // ring
   logic                c_valid [DEPTH];
   logic [SEQ_W-1:0]    c_seq   [DEPTH];
   logic [TIME_W-1:0]   c_time  [DEPTH];
   logic [TAG_BITS-1:0] c_tag   [DEPTH];
   logic [LEN_W-1:0]    c_len   [DEPTH];
   logic                shift;
   logic                wb_valid;

   // head entry, with the new frame dropped in at its free slot
   logic                e_valid;
   logic [SEQ_W-1:0]    e_seq;
   logic [TIME_W-1:0]   e_time;
   logic [TAG_BITS-1:0] e_tag;
   logic [LEN_W-1:0]    e_len;

   // emit request
   logic emit, can_emit, fire;
   logic [KIND_W-1:0] em_kind;
   logic [SEQ_W-1:0] em_seq;
   logic [TAG_BITS-1:0] em_tag;
   logic [START_W-1:0] em_start;
   logic [LEN_W-1:0] em_len;

   // arrival classification
   logic has_seq, plain, bad, pos_last;
   logic [START_W-1:0] start;
   logic [LEN_W-1:0] plen, seq_len;
   logic [SEQ_W-1:0] lr_next, gap_dist;
   logic expired, is_match, stale;
   logic rel_n, exp_n, found_n;
   logic [SEQ_W-1:0] best_n;

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         if (i < DEPTH - 1) begin : g_mid
            sorb_cell #(.TAG_BITS(TAG_BITS)) u_cell (
               .clock(clock), .reset(reset), .shift_en(shift),
               .in_valid(c_valid[i+1]), .in_seq(c_seq[i+1]),
               .in_time(c_time[i+1]), .in_tag(c_tag[i+1]), .in_len(c_len[i+1]),
               .out_valid(c_valid[i]), .out_seq(c_seq[i]), .out_time(c_time[i]),
               .out_tag(c_tag[i]), .out_len(c_len[i])
            );
         end else begin : g_tail
            sorb_cell #(.TAG_BITS(TAG_BITS)) u_cell (
               .clock(clock), .reset(reset), .shift_en(shift),
               .in_valid(wb_valid), .in_seq(e_seq), .in_time(e_time),
               .in_tag(e_tag), .in_len(e_len),
               .out_valid(c_valid[i]), .out_seq(c_seq[i]), .out_time(c_time[i]),
               .out_tag(c_tag[i]), .out_len(c_len[i])
            );
         end
      end
   endgenerate

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         REG_TIMEOUT:     prdata = {1'b0, timeout_ff};
         REG_FLAGS_SEQ:   prdata = {16'd0, flags_seq_ff};
         REG_FLAGS_PLAIN: prdata = {16'd0, flags_plain_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= '0;
         flags_seq_ff   <= FLAGS_SEQ_RESET;
         flags_plain_ff <= FLAGS_PLAIN_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_TIMEOUT:     timeout_ff     <= pwdata[TIMEOUT_W-1:0];
            REG_FLAGS_SEQ:   flags_seq_ff   <= pwdata[FLAGS_W-1:0];
            REG_FLAGS_PLAIN: flags_plain_ff <= pwdata[FLAGS_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath helpers
   assign has_seq  = (flags_ff == flags_seq_ff);
   assign plain    = !has_seq && (flags_ff == flags_plain_ff);
   assign start    = has_seq ? START_SEQ : START_PLAIN;
   assign bad      = (!has_seq && !plain) || (size_ff < LEN_W'(start));
   assign plen     = size_ff - LEN_W'(start);
   assign seq_len  = size_ff - LEN_W'(START_SEQ);
   assign lr_next  = lr_ff + 1'b1;
   assign pos_last = (pos_ff == LAST_POS);

   always_comb begin
      if (insert_ff && (pos_ff == free_ff)) begin
         e_valid = 1'b1;
         e_seq   = seq_ff;
         e_time  = now_ff;
         e_tag   = tag_ff;
         e_len   = seq_len;
      end else begin
         e_valid = c_valid[0];
         e_seq   = c_seq[0];
         e_time  = c_time[0];
         e_tag   = c_tag[0];
         e_len   = c_len[0];
      end
   end

   assign is_match = e_valid && (e_seq == lr_next);
   assign expired  = (now_ff - e_time) >= {1'b0, timeout_ff};
   assign gap_dist = e_seq - lr_next;
   assign stale    = e_valid && !seq_after(e_seq, lr_ff);
   assign can_emit = !pend_v_ff || !out_v_ff || !rsp_stall;
   assign fire     = emit && can_emit;

   // pass summary including the head entry of this cycle
   always_comb begin
      rel_n   = rel_ff;
      exp_n   = exp_ff;
      found_n = found_ff;
      best_n  = best_ff;
      if (is_match) begin
         rel_n = rel_ff || fire;
      end else if (e_valid) begin
         exp_n = exp_ff || expired;
         if (!found_ff || (gap_dist < best_ff)) begin
            found_n = 1'b1;
            best_n  = gap_dist;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      lr_in         = lr_ff;
      pos_in        = pos_ff;
      free_in       = free_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      insert_in     = insert_ff;
      rel_in        = rel_ff;
      exp_in        = exp_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      shift         = 1'b0;
      wb_valid      = e_valid;
      emit          = 1'b0;
      em_kind       = KIND_LATE;
      em_seq        = seq_ff;
      em_tag        = tag_ff;
      em_start      = START_SEQ;
      em_len        = seq_len;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ARRIVE;
            end
         end
         ST_ARRIVE: begin
            insert_in = 1'b0;
            pos_in    = '0;
            rel_in    = 1'b0;
            exp_in    = 1'b0;
            found_in  = 1'b0;
            best_in   = '0;
            if (action_ff && src_ff) begin
               if (bad) begin
                  emit     = 1'b1;
                  em_kind  = KIND_BAD;
                  em_seq   = '0;
                  em_start = '0;
                  em_len   = '0;
                  if (can_emit) state_in = ST_PASS;
               end else if (plain || (timeout_ff == '0)) begin
                  emit     = 1'b1;
                  em_kind  = KIND_FORWARD;
                  em_seq   = has_seq ? seq_ff : '0;
                  em_start = start;
                  em_len   = plen;
                  if (can_emit) state_in = ST_PASS;
               end else begin
                  dup_in        = 1'b0;
                  free_found_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end else begin
               state_in = ST_PASS;
            end
         end
         ST_SCAN: begin
            shift = 1'b1;
            if (c_valid[0] && (c_seq[0] == seq_ff)) dup_in = 1'b1;
            if (!c_valid[0] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_in       = pos_ff;
            end
            pos_in = pos_last ? '0 : pos_ff + 1'b1;
            if (pos_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (dup_ff || !seq_after(seq_ff, lr_ff) || !free_found_ff) begin
               emit    = 1'b1;
               em_kind = (dup_ff || !seq_after(seq_ff, lr_ff)) ? KIND_LATE : KIND_FULL;
               if (can_emit) state_in = ST_PASS;
            end else begin
               insert_in = 1'b1;
               state_in  = ST_PASS;
            end
         end
         ST_PASS: begin
            if (is_match) begin
               emit     = 1'b1;
               em_kind  = KIND_RELEASE;
               em_seq   = e_seq;
               em_tag   = e_tag;
               em_len   = e_len;
               shift    = can_emit;
               wb_valid = 1'b0;
               if (can_emit) lr_in = lr_next;
            end else begin
               shift = 1'b1;
            end
            if (shift) begin
               rel_in   = rel_n;
               exp_in   = exp_n;
               found_in = found_n;
               best_in  = best_n;
               pos_in   = pos_last ? '0 : pos_ff + 1'b1;
               if (pos_last) begin
                  insert_in = 1'b0;
                  rel_in    = 1'b0;
                  exp_in    = 1'b0;
                  found_in  = 1'b0;
                  best_in   = '0;
                  if (!rel_n) begin
                     if (exp_n) begin
                        // skip the gap up to the nearest held number
                        lr_in = lr_ff + best_n;
                     end else begin
                        state_in = ST_DROP;
                     end
                  end
               end
            end
         end
         ST_DROP: begin
            if (stale) begin
               emit     = 1'b1;
               em_seq   = e_seq;
               em_tag   = e_tag;
               em_len   = e_len;
               shift    = can_emit;
               wb_valid = 1'b0;
            end else begin
               shift = 1'b1;
            end
            if (shift) begin
               pos_in = pos_last ? '0 : pos_ff + 1'b1;
               if (pos_last) state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!pend_v_ff || !out_v_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result staging: the newest result waits in the pending stage so the
   // final one of a request can be marked last
   always_comb begin
      pend_v_in     = pend_v_ff;
      pend_kind_in  = pend_kind_ff;
      pend_seq_in   = pend_seq_ff;
      pend_tag_in   = pend_tag_ff;
      pend_start_in = pend_start_ff;
      pend_len_in   = pend_len_ff;
      out_v_in      = out_v_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_seq_in    = out_seq_ff;
      out_tag_in    = out_tag_ff;
      out_start_in  = out_start_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;
      if ((fire || ((state_ff == ST_FINISH) && can_emit)) && pend_v_ff) begin
         out_v_in     = 1'b1;
         out_kind_in  = pend_kind_ff;
         out_seq_in   = pend_seq_ff;
         out_tag_in   = pend_tag_ff;
         out_start_in = pend_start_ff;
         out_len_in   = pend_len_ff;
         out_last_in  = (state_ff == ST_FINISH);
         pend_v_in    = 1'b0;
      end
      if (fire) begin
         pend_v_in     = 1'b1;
         pend_kind_in  = em_kind;
         pend_seq_in   = em_seq;
         pend_tag_in   = em_tag;
         pend_start_in = em_start;
         pend_len_in   = em_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lr_ff         <= '1;
         pos_ff        <= '0;
         free_ff       <= '0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         insert_ff     <= 1'b0;
         rel_ff        <= 1'b0;
         exp_ff        <= 1'b0;
         found_ff      <= 1'b0;
         best_ff       <= '0;
         pend_v_ff     <= 1'b0;
         out_v_ff      <= 1'b0;
         out_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lr_ff         <= lr_in;
         pos_ff        <= pos_in;
         free_ff       <= free_in;
         dup_ff        <= dup_in;
         free_found_ff <= free_found_in;
         insert_ff     <= insert_in;
         rel_ff        <= rel_in;
         exp_ff        <= exp_in;
         found_ff      <= found_in;
         best_ff       <= best_in;
         pend_v_ff     <= pend_v_in;
         out_v_ff      <= out_v_in;
         out_last_ff   <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff  <= pend_kind_in;
      pend_seq_ff   <= pend_seq_in;
      pend_tag_ff   <= pend_tag_in;
      pend_start_ff <= pend_start_in;
      pend_len_ff   <= pend_len_in;
      out_kind_ff   <= out_kind_in;
      out_seq_ff    <= out_seq_in;
      out_tag_ff    <= out_tag_in;
      out_start_ff  <= out_start_in;
      out_len_ff    <= out_len_in;
      if ((state_ff == ST_IDLE) && req_valid) begin
         action_ff <= req_action;
         now_ff    <= req_now_time;
         src_ff    <= req_source_ok;
         flags_ff  <= req_flags_word;
         seq_ff    <= req_seq_number;
         tag_ff    <= req_frame_tag;
         size_ff   <= req_frame_size;
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = out_v_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_out_seq       = out_seq_ff;
   assign rsp_out_tag       = out_tag_ff;
   assign rsp_payload_start = out_start_ff;
   assign rsp_payload_len   = out_len_ff;
   assign rsp_last          = out_last_ff;

endmodule

[rtl/core/sorb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorb_checker
// Port-level checks of the reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
module sorb_checker #(
   parameter int TAG_BITS = sorb_pkg::TAG_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sorb_pkg::KIND_W-1:0]  rsp_kind,
   input logic [sorb_pkg::SEQ_W-1:0]   rsp_out_seq,
   input logic [TAG_BITS-1:0]          rsp_out_tag,
   input logic [sorb_pkg::START_W-1:0] rsp_payload_start,
   input logic [sorb_pkg::LEN_W-1:0]   rsp_payload_len
);
   import sorb_pkg::*;

   // a stalled request result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_seq)
         && $stable(rsp_out_tag))
      else $error("stalled result changed");

   // the block works on one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_release_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_RELEASE) |-> rsp_payload_start == START_SEQ)
      else $error("released frame with wrong payload offset");

   a_bad_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_BAD) |-> (rsp_out_seq == '0)
         && (rsp_payload_len == '0) && (rsp_payload_start == '0))
      else $error("bad header result carries payload fields");

endmodule

bind sequence_reorder_buffer sorb_checker #(.TAG_BITS(TAG_BITS)) u_sorb_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
   .rsp_out_seq(rsp_out_seq), .rsp_out_tag(rsp_out_tag),
   .rsp_payload_start(rsp_payload_start), .rsp_payload_len(rsp_payload_len)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sequence_reorder_buffer. Frame descriptors and time
// updates are sent with random gaps, results are taken under random stall and
// compared field by field against an in-bench model of the slot table, the
// in-order release, the timeout gap skip and the late/full drops.
// ----------------------------------------------------------------------------
module testbench;
   import sorb_pkg::*;

   localparam int SLOTS      = DEPTH_DEF;
   localparam int MAX_OUT    = SLOTS + 2;
   localparam int SETTLE     = 400;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      kind_type            kind;
      logic [SEQ_W-1:0]    seq;
      logic [9:0]          tag;
      logic [START_W-1:0]  start;
      logic [LEN_W-1:0]    len;
      logic                last;
   } report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_action = 1'b0;
   logic [TIME_W-1:0]    req_now_time = '0;
   logic                 req_source_ok = 1'b0;
   logic [FLAGS_W-1:0]   req_flags_word = '0;
   logic [SEQ_W-1:0]     req_seq_number = '0;
   logic [9:0]           req_frame_tag = '0;
   logic [LEN_W-1:0]     req_frame_size = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic [SEQ_W-1:0]     rsp_out_seq;
   logic [9:0]           rsp_out_tag;
   logic [START_W-1:0]   rsp_payload_start;
   logic [LEN_W-1:0]     rsp_payload_len;
   logic                 rsp_last;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_W-1:0]    paddr = '0;
   logic [DATA_W-1:0]    pwdata = '0;
   logic [DATA_W-1:0]    prdata;
   logic                 pready;

   sequence_reorder_buffer DUT (.*);

   // model state
   logic [30:0]          hold_us;
   logic [15:0]          seq_flags;
   logic [15:0]          plain_flags;
   bit                   held_valid [SLOTS];
   logic [31:0]          held_seq [SLOTS];
   logic [31:0]          held_time [SLOTS];
   logic [9:0]           held_tag [SLOTS];
   logic [15:0]          held_len [SLOTS];
   logic [31:0]          released_seq;

   report_type           step_reports [$];
   report_type           pending_reports [$];
   int                   mismatches = 0;
   bit                   quiet = 1'b0;
   logic [31:0]          uptime = '0;

   initial forever #1 clock = ~clock;

   always @(posedge clock) rsp_stall <= !quiet && ($urandom_range(99) < 11);

   function automatic bit is_after(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d != 0 && d < 32'h8000_0000;
   endfunction

   function automatic void add_report(kind_type k, logic [31:0] s, logic [9:0] t,
                                      logic [3:0] st, logic [15:0] l);
      report_type r;
      if (step_reports.size() >= MAX_OUT) return;
      r.kind = k; r.seq = s; r.tag = t; r.start = st; r.len = l; r.last = 1'b0;
      step_reports.push_back(r);
   endfunction

   function automatic void release_run();
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            if (held_valid[i] && held_seq[i] == released_seq + 1) begin
               add_report(KIND_RELEASE, held_seq[i], held_tag[i], START_SEQ, held_len[i]);
               held_valid[i] = 1'b0;
               released_seq = released_seq + 1;
               again = 1'b1;
            end
         end
      end
   endfunction

   function automatic void predict_reorder(bit action, logic [31:0] now, bit src,
                                           logic [15:0] flags, logic [31:0] seq,
                                           logic [9:0] tag, logic [15:0] size);
      bit has_seq, plain, dup, expired, found;
      int free_slot;
      logic [3:0] start;
      logic [31:0] best, d;
      step_reports.delete();
      if (action && src) begin
         has_seq = (flags == seq_flags);
         plain = !has_seq && (flags == plain_flags);
         start = has_seq ? START_SEQ : START_PLAIN;
         if ((!has_seq && !plain) || size < start) begin
            add_report(KIND_BAD, '0, tag, '0, '0);
         end else if (plain || hold_us == 0) begin
            add_report(KIND_FORWARD, has_seq ? seq : '0, tag, start, size - start);
         end else begin
            dup = 1'b0;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (held_valid[i]) begin
                  if (held_seq[i] == seq) dup = 1'b1;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (dup || !is_after(seq, released_seq)) begin
               add_report(KIND_LATE, seq, tag, START_SEQ, size - 16'd12);
            end else if (free_slot < 0) begin
               add_report(KIND_FULL, seq, tag, START_SEQ, size - 16'd12);
            end else begin
               held_valid[free_slot] = 1'b1;
               held_seq[free_slot] = seq;
               held_time[free_slot] = now;
               held_tag[free_slot] = tag;
               held_len[free_slot] = size - 16'd12;
            end
         end
      end
      forever begin
         release_run();
         expired = 1'b0;
         for (int i = 0; i < SLOTS; i++)
            if (held_valid[i] && (now - held_time[i]) >= {1'b0, hold_us}) expired = 1'b1;
         if (!expired) break;
         // skip the gap up to the nearest held number
         found = 1'b0;
         best = '0;
         for (int i = 0; i < SLOTS; i++) begin
            if (held_valid[i]) begin
               d = held_seq[i] - (released_seq + 1);
               if (!found || d < best) begin
                  best = d;
                  found = 1'b1;
               end
            end
         end
         released_seq = released_seq + best;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (held_valid[i] && !is_after(held_seq[i], released_seq)) begin
            add_report(KIND_LATE, held_seq[i], held_tag[i], START_SEQ, held_len[i]);
            held_valid[i] = 1'b0;
         end
      end
      if (step_reports.size() > 0) step_reports[step_reports.size()-1].last = 1'b1;
      foreach (step_reports[i]) pending_reports.push_back(step_reports[i]);
   endfunction

   // result checker
   always @(posedge clock) begin
      report_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result kind=%0d seq=%h tag=%0d", rsp_kind,
                        rsp_out_seq, rsp_out_tag);
         end else begin
            e = pending_reports.pop_front();
            if (rsp_kind !== e.kind || rsp_out_seq !== e.seq || rsp_out_tag !== e.tag ||
                rsp_payload_start !== e.start || rsp_payload_len !== e.len ||
                rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp k=%0d s=%h t=%0d st=%0d l=%0d last=%b %s",
                           e.kind, e.seq, e.tag, e.start, e.len, e.last,
                           $sformatf("got k=%0d s=%h t=%0d st=%0d l=%0d last=%b",
                                     rsp_kind, rsp_out_seq, rsp_out_tag,
                                     rsp_payload_start, rsp_payload_len, rsp_last));
            end
         end
      end
   end

   // watchdog on cycles with no transfer at all
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_request(bit action, logic [31:0] now, bit src, logic [15:0] flags,
                               logic [31:0] seq, logic [9:0] tag, logic [15:0] size);
      if (!quiet && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_now_time <= now;
      req_source_ok <= src;
      req_flags_word <= flags;
      req_seq_number <= seq;
      req_frame_tag <= tag;
      req_frame_size <= size;
      do @(posedge clock); while (req_stall);
      predict_reorder(action, now, src, flags, seq, tag, size);
   endtask

   task automatic send_frame(logic [31:0] seq, logic [15:0] size);
      send_request(1'b1, uptime, 1'b1, seq_flags, seq, 10'($urandom), size);
   endtask

   // pause the sender until every result is in, then let the block settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_TIMEOUT:     hold_us = value[30:0];
         REG_FLAGS_SEQ:   seq_flags = value[15:0];
         REG_FLAGS_PLAIN: plain_flags = value[15:0];
         default: ;
      endcase
   endtask

   task automatic test_direct_forward();
      send_request(1'b1, 32'h0, 1'b1, plain_flags, 32'h0, 10'd0, 16'd8);
      send_request(1'b1, 32'hFFFF_FFFF, 1'b1, plain_flags, 32'hFFFF_FFFF, 10'd1023, 16'hFFFF);
      send_request(1'b1, 32'h1, 1'b1, seq_flags, 32'hFFFF_FFFF, 10'h2AA, 16'd12);
      send_request(1'b1, 32'h2, 1'b1, seq_flags, 32'h5555_AAAA, 10'h155, 16'd11);
      send_request(1'b1, 32'h3, 1'b1, plain_flags, 32'h1, 10'd7, 16'd7);
      send_request(1'b1, 32'h4, 1'b1, 16'hFFFF, 32'h2, 10'd9, 16'd100);
      send_request(1'b1, 32'h5, 1'b0, seq_flags, 32'h3, 10'd3, 16'd100);
      send_request(1'b0, 32'h6, 1'b1, seq_flags, 32'h4, 10'd4, 16'd100);
      wait_drained();
      // both flag registers equal: the sequenced meaning wins
      write_register(REG_FLAGS_PLAIN, {16'h0, FLAGS_SEQ_RESET});
      send_request(1'b1, 32'h7, 1'b1, FLAGS_SEQ_RESET, 32'h77, 10'd5, 16'd40);
      send_request(1'b1, 32'h8, 1'b1, FLAGS_SEQ_RESET, 32'h78, 10'd6, 16'd9);
      wait_drained();
      write_register(REG_FLAGS_PLAIN, {16'h0, FLAGS_PLAIN_RESET});
   endtask

   task automatic test_hold_and_release();
      logic [31:0] base;
      write_register(REG_TIMEOUT, 32'd100);
      uptime = 32'd1000;
      send_frame(32'd1, 16'd50);
      send_frame(32'd0, 16'd60);
      send_frame(32'd5, 16'd70);
      send_frame(32'd5, 16'd70);
      send_frame(32'd0, 16'd20);
      uptime = 32'd1100;
      send_request(1'b0, uptime, 1'b1, '0, '0, '0, '0);
      // far ahead: one held number near the serial horizon
      base = released_seq;
      send_frame(base + 32'h7FFF_FFFF, 16'd30);
      send_frame(base + 32'd4, 16'd30);
      send_frame(base + 32'h8000_0001, 16'd30);
      uptime = 32'd1300;
      send_request(1'b0, uptime, 1'b1, '0, '0, '0, '0);
      wait_drained();
   endtask

   task automatic test_full_table();
      logic [31:0] base;
      write_register(REG_TIMEOUT, 32'h7FFF_FFFF);
      base = released_seq;
      for (int i = 2; i <= SLOTS + 2; i++) send_frame(base + i, 16'(12 + i));
      send_frame(base + 1, 16'd13);
      wait_drained();
   endtask

   task automatic test_timeout_to_zero();
      logic [31:0] base;
      write_register(REG_TIMEOUT, 32'd1000);
      base = released_seq;
      send_frame(base + 3, 16'd80);
      send_frame(base + 7, 16'd81);
      send_frame(base + 4, 16'd82);
      wait_drained();
      write_register(REG_TIMEOUT, 32'd0);
      send_request(1'b0, uptime + 1, 1'b1, '0, '0, '0, '0);
      wait_drained();
   endtask

   task automatic random_traffic(int count);
      bit action, src;
      logic [15:0] flags, size;
      logic [31:0] seq, step;
      int r;
      for (int n = 0; n < count; n++) begin
         step = (hold_us == 0) ? 32'd50 : ({1'b0, hold_us} >> 2) + 1;
         if (step > 32'd100000) step = 32'd100000;
         r = $urandom_range(99);
         if (r < 4) uptime = uptime + {1'b0, hold_us} + 1;
         else if (r < 6) uptime = $urandom;
         else uptime = uptime + $urandom_range(0, step);
         action = $urandom_range(99) < 90;
         src = $urandom_range(99) < 95;
         r = $urandom_range(99);
         flags = (r < 75) ? seq_flags : (r < 90) ? plain_flags : 16'($urandom);
         r = $urandom_range(99);
         if (r < 70) seq = released_seq + 1 + $urandom_range(0, 12);
         else if (r < 80) seq = released_seq - $urandom_range(0, 5);
         else if (r < 90) seq = $urandom;
         else seq = released_seq + 1 + $urandom_range(0, 40);
         size = ($urandom_range(99) < 80) ? 16'($urandom_range(12, 1500)) : 16'($urandom);
         send_request(action, uptime, src, flags, seq, 10'($urandom), size);
      end
      wait_drained();
   endtask

   task automatic test_random_settings();
      write_register(REG_TIMEOUT, 32'd1000);
      random_traffic(50);
      write_register(REG_FLAGS_SEQ, $urandom);
      write_register(REG_FLAGS_PLAIN, $urandom);
      write_register(REG_TIMEOUT, 32'd1);
      quiet = 1'b1;
      random_traffic(45);
      quiet = 1'b0;
      write_register(REG_FLAGS_SEQ, 32'hFFFF);
      write_register(REG_FLAGS_PLAIN, 32'h0);
      write_register(REG_TIMEOUT, 32'h7FFF_FFFF);
      random_traffic(40);
      write_register(REG_TIMEOUT, 32'd0);
      random_traffic(35);
      write_register(REG_FLAGS_SEQ, {16'h0, FLAGS_SEQ_RESET});
      write_register(REG_FLAGS_PLAIN, {16'h0, FLAGS_PLAIN_RESET});
      write_register(REG_TIMEOUT, 32'd5000);
      uptime = 32'hFFFF_0000;
      random_traffic(52);
   endtask

   initial begin
      hold_us = '0;
      seq_flags = FLAGS_SEQ_RESET;
      plain_flags = FLAGS_PLAIN_RESET;
      released_seq = 32'hFFFF_FFFF;
      foreach (held_valid[i]) held_valid[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE) @(posedge clock);
      test_direct_forward();
      test_hold_and_release();
      test_full_table();
      test_timeout_to_zero();
      test_random_settings();
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
